@@ hdl/rrfs_pkg.sv @@
// ----------------------------------------------------------------------------
// rrfs_pkg
// Shared constants, command codes and types of the row range filter scan.
// ----------------------------------------------------------------------------
package rrfs_pkg;

   localparam int ROW_COLUMNS = 100;
   localparam int POS_W       = (ROW_COLUMNS > 1) ? $clog2(ROW_COLUMNS) : 1;
   localparam int WORD_W      = 64;
   localparam int COL_W       = 7;
   localparam int LIMIT_W     = 10;
   localparam int COUNT_W     = 32;
   localparam int CMD_W       = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CMP_W       = (POS_W > COL_W) ? POS_W : COL_W;

   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_SELECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LIMIT     = 2'd3;

   localparam logic [LIMIT_W-1:0] ROW_LIMIT_RESET = 10'd10;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
   localparam logic [POS_W-1:0]   POS_LAST        = POS_W'(ROW_COLUMNS - 1);

   typedef struct packed {
      logic               emit;
      logic [POS_W-1:0]   pos;
      logic [COUNT_W-1:0] count;
   } rrfs_status_type;

endpackage

@@ hdl/rrfs_ifs.sv @@
// ----------------------------------------------------------------------------
// rrfs request and response channels
// Valid/ready channels carrying one command word in and one result out.
// ----------------------------------------------------------------------------
interface rrfs_req_if;
   import rrfs_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic signed [WORD_W-1:0] word;

   modport source (output valid, command, word, input ready);
   modport sink   (input valid, command, word, output ready);
endinterface

interface rrfs_rsp_if;
   import rrfs_pkg::*;

   logic                valid;
   logic                ready;
   logic                out_valid;
   logic signed [WORD_W-1:0] out_word;
   logic [COL_W-1:0]    out_column;
   logic                out_last;
   logic [COUNT_W-1:0]  match_count;

   modport source (output valid, out_valid, out_word, out_column, out_last, match_count,
                   input ready);
   modport sink   (input valid, out_valid, out_word, out_column, out_last, match_count,
                   output ready);
endinterface

@@ hdl/row_range_filter_scan.sv @@
// ----------------------------------------------------------------------------
// row_range_filter_scan
// Range predicate filter over a stream of 64-bit column words. Rows of
// ROW_COLUMNS words pass through a chain of word cells, so each selected row
// comes out one row late while the next row streams in.
//
//   channel   dir   handshake        payload
//   req       in    valid / ready    command, word
//   rsp       out   valid / ready    out_valid, out_word, out_column,
//                                    out_last, match_count
//   csr       in    csr_we           csr_index, csr_wdata
//
// one transfer in per cycle while req.ready holds, its result in the next cycle from the output register
// the chain of ROW_COLUMNS cells advances once per data or drain transfer
// req.ready drops during reset and while a result waits in the output register
// reset clears position, flags, count, settings and result valid; cell words and result fields stay undefined
// ----------------------------------------------------------------------------
module row_range_filter_scan (
   input  logic                             clock,
   input  logic                             reset,
   rrfs_req_if.sink                         req,
   rrfs_rsp_if.source                       rsp,
   input  logic                             csr_we,
   input  logic [rrfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rrfs_pkg::WORD_W-1:0]      csr_wdata
);
   import rrfs_pkg::*;

   logic [COL_W-1:0]          column_select_ff;
   logic signed [WORD_W-1:0]  range_low_ff;
   logic signed [WORD_W-1:0]  range_high_ff;
   logic [LIMIT_W-1:0]        row_limit_ff;

   logic                      accept;
   logic                      shift_en;
   logic [WORD_W-1:0]         shift_word;
   logic [WORD_W-1:0]         tap [ROW_COLUMNS];
   rrfs_status_type           status;
   logic [CMP_W-1:0]          pos_ext;

   logic                      rsp_valid_ff,  rsp_valid_in;
   logic                      out_valid_ff;
   logic [WORD_W-1:0]         out_word_ff;
   logic [COL_W-1:0]          out_column_ff;
   logic                      out_last_ff;
   logic [COUNT_W-1:0]        match_count_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         column_select_ff <= '0;
         range_low_ff     <= '0;
         range_high_ff    <= '0;
         row_limit_ff     <= ROW_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COLUMN_SELECT: column_select_ff <= csr_wdata[COL_W-1:0];
            CSR_RANGE_LOW:     range_low_ff     <= csr_wdata;
            CSR_RANGE_HIGH:    range_high_ff    <= csr_wdata;
            CSR_ROW_LIMIT:     row_limit_ff     <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req.ready = !reset && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign shift_en  = accept && (req.command == CMD_DATA || req.command == CMD_DRAIN);
   assign shift_word = (req.command == CMD_DATA) ? req.word : '0;

   rrfs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (req.command),
      .word          (req.word),
      .column_select (column_select_ff),
      .range_low     (range_low_ff),
      .range_high    (range_high_ff),
      .row_limit     (row_limit_ff),
      .status        (status)
   );

   // row delay chain
   for (genvar i = 0; i < ROW_COLUMNS; i++) begin : g_cell
      if (i == 0) begin : g_head
         rrfs_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .d        (shift_word),
            .q        (tap[i])
         );
      end else begin : g_body
         rrfs_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .d        (tap[i-1]),
            .q        (tap[i])
         );
      end
   end

   assign pos_ext = CMP_W'(status.pos);

   // output register
   assign rsp_valid_in = accept ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_valid_ff   <= status.emit;
         out_word_ff    <= status.emit ? tap[ROW_COLUMNS-1] : '0;
         out_column_ff  <= status.emit ? pos_ext[COL_W-1:0] : '0;
         out_last_ff    <= status.emit && (status.pos == POS_LAST);
         match_count_ff <= status.count;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_valid   = out_valid_ff;
   assign rsp.out_word    = out_word_ff;
   assign rsp.out_column  = out_column_ff;
   assign rsp.out_last    = out_last_ff;
   assign rsp.match_count = match_count_ff;
endmodule

@@ hdl/rrfs_cell.sv @@
// ----------------------------------------------------------------------------
// rrfs_cell
// One word of the row delay line; takes its neighbor's word on each step.
// ----------------------------------------------------------------------------
module rrfs_cell (
   input  logic                          clock,
   input  logic                          shift_en,
   input  logic [rrfs_pkg::WORD_W-1:0]   d,
   output logic [rrfs_pkg::WORD_W-1:0]   q
);
   import rrfs_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   assign word_in = shift_en ? d : word_ff;

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign q = word_ff;
endmodule

@@ hdl/rrfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrfs_ctrl
// Column position, range test, row close and saturating match count.
// ----------------------------------------------------------------------------
module rrfs_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [rrfs_pkg::CMD_W-1:0]         command,
   input  logic signed [rrfs_pkg::WORD_W-1:0] word,
   input  logic [rrfs_pkg::COL_W-1:0]         column_select,
   input  logic signed [rrfs_pkg::WORD_W-1:0] range_low,
   input  logic signed [rrfs_pkg::WORD_W-1:0] range_high,
   input  logic [rrfs_pkg::LIMIT_W-1:0]       row_limit,
   output rrfs_pkg::rrfs_status_type          status
);
   import rrfs_pkg::*;

   logic [POS_W-1:0]   pos_ff,   pos_in;
   logic               hit_ff,   hit_in;
   logic               emit_ff,  emit_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic is_data;
   logic is_step;
   logic at_select;
   logic in_range;
   logic row_hit;
   logic row_end;

   assign is_data   = command == CMD_DATA;
   assign is_step   = is_data || command == CMD_DRAIN;
   assign at_select = CMP_W'(pos_ff) == CMP_W'(column_select);
   assign in_range  = (word >= range_low) && (word <= range_high);
   assign row_hit   = is_data && (hit_ff || (at_select && in_range));
   assign row_end   = pos_ff == POS_LAST;

   always_comb begin
      pos_in   = pos_ff;
      hit_in   = hit_ff;
      emit_in  = emit_ff;
      count_in = count_ff;
      if (accept) begin
         unique case (command)
            CMD_START: begin
               pos_in   = '0;
               hit_in   = 1'b0;
               emit_in  = 1'b0;
               count_in = '0;
            end
            CMD_DATA, CMD_DRAIN: begin
               if (row_end) begin
                  pos_in  = '0;
                  hit_in  = 1'b0;
                  emit_in = row_hit && (count_ff < COUNT_W'(row_limit));
                  if (row_hit && count_ff != COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
                  hit_in = row_hit;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         hit_ff   <= 1'b0;
         emit_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         hit_ff   <= hit_in;
         emit_ff  <= emit_in;
         count_ff <= count_in;
      end
   end

   assign status.emit  = emit_ff && is_step;
   assign status.pos   = pos_ff;
   assign status.count = count_in;
endmodule

@@ hdl/rrfs_checker.sv @@
// ----------------------------------------------------------------------------
// rrfs_checker
// Port-level checks of the row range filter scan, bound to the top level.
// ----------------------------------------------------------------------------
module rrfs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [rrfs_pkg::CMD_W-1:0]     req_command,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_out_valid,
   input logic [rrfs_pkg::WORD_W-1:0]    rsp_out_word,
   input logic [rrfs_pkg::COL_W-1:0]     rsp_out_column,
   input logic                           rsp_out_last,
   input logic [rrfs_pkg::COUNT_W-1:0]   rsp_match_count
);
   import rrfs_pkg::*;

   logic [COL_W-1:0] last_column;

   assign last_column = COL_W'(ROW_COLUMNS - 1);

   // start transfer gives a cleared count and no word
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_START |=>
         rsp_valid && rsp_match_count == '0 && !rsp_out_valid)
      else $error("start did not clear the result");

   // reserved command passes no word
   a_rsvd_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_RSVD |=> rsp_valid && !rsp_out_valid)
      else $error("reserved command produced a word");

   // no word means zero word fields
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |->
         rsp_out_word == '0 && rsp_out_column == '0 && !rsp_out_last)
      else $error("word fields set without a passed word");

   // last flag only at the final column
   a_last_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |-> rsp_out_valid && rsp_out_column == last_column)
      else $error("last flag away from the final column");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_count)
         && $stable(rsp_out_word))
      else $error("stalled result changed");
endmodule

bind row_range_filter_scan rrfs_checker u_rrfs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .req_command     (req.command),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_out_valid   (rsp.out_valid),
   .rsp_out_word    (rsp.out_word),
   .rsp_out_column  (rsp.out_column),
   .rsp_out_last    (rsp.out_last),
   .rsp_match_count (rsp.match_count)
);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for row_range_filter_scan. A queue of command words
// feeds a valid/ready driver. A monitor predicts one result per accepted
// transfer with its own model of the row delay store, the hit test and the
// saturating match count, and compares every result field in order. Phases
// reprogram the column select, range bounds and row limit while the block is
// idle, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import rrfs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [WORD_W-1:0] WORD_MAX = ~WORD_MIN;
   localparam int REPORT_CAP = 100;
   localparam int IDLE_TIMEOUT = 20000;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [WORD_W-1:0] word;
   } scan_in_type;

   typedef struct packed {
      logic                     pass;
      logic signed [WORD_W-1:0] word;
      logic [COL_W-1:0]         column;
      logic                     last;
      logic [COUNT_W-1:0]       count;
   } scan_out_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;

   rrfs_req_if req_ch ();
   rrfs_rsp_if rsp_ch ();

   row_range_filter_scan dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model of the block
   logic [COL_W-1:0]         sel_column;
   logic signed [WORD_W-1:0] bound_low;
   logic signed [WORD_W-1:0] bound_high;
   logic [LIMIT_W-1:0]       pass_limit;
   logic signed [WORD_W-1:0] delay_row [ROW_COLUMNS];
   int                       fill_pos;
   logic                     row_hit;
   logic                     row_pass;
   logic [COUNT_W-1:0]       hit_rows;

   scan_in_type  scan_queue [$];
   scan_out_type predicted_out [$];
   int        error_count = 0;
   int        results_seen = 0;
   bit        req_accepted = 1'b0;
   int        stall_left = 0;
   int        next_stall_at = 300;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic signed [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic bit calm();
      return results_seen >= 500 && results_seen < 800;
   endfunction

   // word for the compared column: bounds, neighbors, extremes, inside the range or random
   function automatic logic signed [WORD_W-1:0] probe_word();
      logic [WORD_W-1:0]        r;
      logic [WORD_W-1:0]        span;
      logic signed [WORD_W-1:0] v;
      r = rand_word();
      span = bound_high - bound_low;
      case ($urandom_range(11))
         0: v = bound_low;
         1: v = bound_high;
         2: v = bound_low - 1;
         3: v = bound_high + 1;
         4: v = WORD_MIN;
         5: v = WORD_MAX;
         6, 7, 8, 9: begin
            if (bound_low <= bound_high && span != '1) begin
               v = bound_low + (r % (span + 1));
            end else begin
               v = r;
            end
         end
         default: v = r;
      endcase
      return v;
   endfunction

   function automatic scan_out_type predict_scan(input logic [CMD_W-1:0] command,
                                                 input logic signed [WORD_W-1:0] value);
      scan_out_type r;
      int        p;
      r = '0;
      p = fill_pos;
      case (command)
         CMD_START: begin
            hit_rows = '0;
            fill_pos = 0;
            row_hit = 1'b0;
            row_pass = 1'b0;
         end
         CMD_RSVD: r.count = hit_rows;
         default: begin
            if (row_pass) begin
               r.pass = 1'b1;
               r.word = delay_row[p];
               r.column = p[COL_W-1:0];
               r.last = (p == ROW_COLUMNS - 1);
            end
            if (command == CMD_DATA) begin
               delay_row[p] = value;
               if (p == sel_column && value >= bound_low && value <= bound_high) begin
                  row_hit = 1'b1;
               end
            end else begin
               delay_row[p] = '0;
               row_hit = 1'b0;
            end
            if (p == ROW_COLUMNS - 1) begin
               row_pass = row_hit && (hit_rows < pass_limit);
               if (row_hit && hit_rows != COUNT_MAX) begin
                  hit_rows++;
               end
               row_hit = 1'b0;
               fill_pos = 0;
            end else begin
               fill_pos = p + 1;
            end
            r.count = hit_rows;
         end
      endcase
      return r;
   endfunction

   task automatic push_item(input logic [CMD_W-1:0] command,
                            input logic signed [WORD_W-1:0] value);
      scan_in_type item;
      item.command = command;
      item.word = value;
      scan_queue.push_back(item);
   endtask

   // one full row, with some ignored words and a few drains mixed in
   task automatic queue_row(input int drain_pct);
      for (int p = 0; p < ROW_COLUMNS; p++) begin
         if ($urandom_range(99) < 3) begin
            push_item(CMD_RSVD, rand_word());
         end
         if ($urandom_range(99) < drain_pct) begin
            push_item(CMD_DRAIN, rand_word());
         end else begin
            push_item(CMD_DATA, (p == sel_column) ? probe_word() : rand_word());
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_COLUMN_SELECT: sel_column = value[COL_W-1:0];
         CSR_RANGE_LOW:     bound_low = value;
         CSR_RANGE_HIGH:    bound_high = value;
         default:           pass_limit = value[LIMIT_W-1:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [COL_W-1:0] col, input logic signed [WORD_W-1:0] lo,
                            input logic signed [WORD_W-1:0] hi, input logic [LIMIT_W-1:0] lim);
      write_reg(CSR_ROW_LIMIT, WORD_W'(lim));
      write_reg(CSR_RANGE_LOW, lo);
      write_reg(CSR_RANGE_HIGH, hi);
      write_reg(CSR_COLUMN_SELECT, WORD_W'(col));
   endtask

   task automatic wait_idle();
      int cycles;
      cycles = 0;
      @(negedge clock);
      while ((scan_queue.size() != 0 || req_ch.valid || predicted_out.size() != 0)
             && cycles < IDLE_TIMEOUT) begin
         @(negedge clock);
         cycles++;
      end
      if (cycles >= IDLE_TIMEOUT) begin
         error_count++;
         $display("%0t: timeout, %0d results still outstanding", $time, predicted_out.size());
      end
      repeat (3) @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin : drive_req
      scan_in_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_accepted) begin
         if (scan_queue.size() != 0 && (calm() || $urandom_range(99) >= 18)) begin
            nxt = scan_queue.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.command <= nxt.command;
            req_ch.word <= nxt.word;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response ready, with long hold-offs that back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else if (results_seen >= next_stall_at) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 80;
         next_stall_at += 600;
      end else begin
         rsp_ch.ready <= calm() || ($urandom_range(99) >= 18);
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      scan_out_type got;
      scan_out_type want;
      if (reset) begin
         req_accepted = 1'b0;
      end else begin
         req_accepted = req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            got = {rsp_ch.out_valid, rsp_ch.out_word, rsp_ch.out_column, rsp_ch.out_last,
                   rsp_ch.match_count};
            if (predicted_out.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_CAP) begin
                  $display("%0t: result transfer with none expected, actual v=%0b w=%h c=%0d",
                           $time, got.pass, got.word, got.column,
                           " l=%0b n=%0d", got.last, got.count);
               end
            end else begin
               want = predicted_out.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= REPORT_CAP) begin
                     $display("%0t: mismatch, expected v=%0b w=%h c=%0d l=%0b n=%0d,",
                              $time, want.pass, want.word, want.column, want.last,
                              want.count, " actual v=%0b w=%h c=%0d l=%0b n=%0d",
                              got.pass, got.word, got.column, got.last, got.count);
                  end
               end
            end
         end
         if (req_accepted) begin
            predicted_out.push_back(predict_scan(req_ch.command, req_ch.word));
         end
      end
   end

   initial begin : stimulus
      logic signed [WORD_W-1:0] lo;
      logic signed [WORD_W-1:0] hi;
      logic signed [WORD_W-1:0] swap;
      int rows;
      int tail;
      int drain_pct;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_START;
      req_ch.word = '0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_COLUMN_SELECT;
      csr_wdata = '0;
      sel_column = '0;
      bound_low = '0;
      bound_high = '0;
      pass_limit = ROW_LIMIT_RESET;
      fill_pos = 0;
      row_hit = 1'b0;
      row_pass = 1'b0;
      hit_rows = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: column 0, range 0..0
      push_item(CMD_START, rand_word());
      push_item(CMD_RSVD, WORD_MAX);
      push_item(CMD_DATA, '0);
      push_item(CMD_DATA, WORD_MAX);
      push_item(CMD_DATA, WORD_MIN);
      push_item(CMD_DATA, -64'sd1);
      push_item(CMD_DATA, 64'sd1);
      push_item(CMD_DATA, 64'h5555_5555_5555_5555);
      push_item(CMD_DATA, 64'hAAAA_AAAA_AAAA_AAAA);
      push_item(CMD_DRAIN, WORD_MAX);
      push_item(CMD_RSVD, WORD_MIN);
      push_item(CMD_START, -64'sd1);
      push_item(CMD_DATA, WORD_MIN);
      push_item(CMD_DRAIN, '0);
      push_item(CMD_START, '0);

      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         lo = rand_word();
         hi = rand_word();
         if (lo > hi) begin
            swap = lo;
            lo = hi;
            hi = swap;
         end
         rows = 1;
         tail = $urandom_range(10, 40);
         drain_pct = 2;
         case (phase)
            0: begin
               configure(7'd0, WORD_MIN, WORD_MAX, 10'd3);
               rows = 2;
               tail = ROW_COLUMNS;
               drain_pct = 0;
            end
            1: configure(7'd99, -64'sd1000, 64'sd1000, 10'd1023);
            2: configure(7'd127, WORD_MIN, WORD_MAX, ROW_LIMIT_RESET);
            3: configure(7'd50, 64'sd100, -64'sd100, 10'd5);
            4: configure(7'd0, '0, '0, 10'd0);
            5: configure(7'($urandom_range(ROW_COLUMNS - 1)), lo, hi, 10'd1);
            6: configure(7'($urandom_range(ROW_COLUMNS - 1)), WORD_MAX, WORD_MAX, 10'd1023);
            default: begin
               configure(7'd99, WORD_MIN, WORD_MIN, 10'd2);
               tail = ROW_COLUMNS;
            end
         endcase
         @(posedge clock);
         push_item(CMD_START, rand_word());
         if (phase % 3 == 1) begin
            repeat ($urandom_range(1, 20)) push_item(CMD_DATA, rand_word());
            push_item(CMD_START, rand_word());
         end
         repeat (rows) queue_row(drain_pct);
         repeat (tail) push_item(CMD_DRAIN, rand_word());
      end

      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
